/* design/fvn_pkg.sv */
// fractal value noise: shared constants for the core, the octave lanes and the checker
// no dependencies
`default_nettype none

package fvn_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned LANE_STAGES = 8;
  // input reg, lane stages, two adder stages, divider setup, one stage per quotient bit
  localparam int unsigned PIPE_DEPTH  = 1 + LANE_STAGES + 3 + OUT_W;

  localparam logic [31:0] HASH_K1   = 32'h85EB_CA6B;
  localparam logic [31:0] HASH_K2   = 32'hC2B2_AE35;
  localparam logic [31:0] HASH_K3   = 32'h27D4_EB2F;
  localparam logic [31:0] SEED_STEP = 32'd7919;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_DIM = 2'd2;

endpackage

`default_nettype wire

/* design/fvn_octave.sv */
// fractal value noise: one octave lane, lattice split, corner hash and smoothstep blend
// depends on fvn_pkg
`default_nettype none

module fvn_octave import fvn_pkg::*; #(
  parameter int unsigned SHIFT     = 0,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic [LANE_STAGES-1:0] adv_i,
  input  wire logic [COORD_W-1:0]     x_i,
  input  wire logic [COORD_W-1:0]     y_i,
  input  wire logic [31:0]            seed_i,
  output logic      [OUT_W-1:0]       val_o
);

  localparam int unsigned FW = FRAC_BITS;
  localparam logic [FW+1:0] THREE_ONE = {2'b11, {FW{1'b0}}};

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

  function automatic logic [OUT_W-1:0] blend(input logic [OUT_W-1:0] a,
                                             input logic [OUT_W-1:0] b,
                                             input logic [FW:0] s);
    logic signed [OUT_W:0]    dif;
    logic signed [FW+OUT_W+2:0] p;
    dif = $signed({1'b0, b}) - $signed({1'b0, a});
    p   = dif * $signed({1'b0, s});
    return a + p[FW+OUT_W-1:FW];
  endfunction

  // stage 1: lattice split
  logic [2*COORD_W-1:0] xs, ys;
  logic [31:0] x0_q, y0_q;
  logic [FW-1:0] fx_q, fy_q;

  assign xs = {{COORD_W{x_i[COORD_W-1]}}, x_i} << SHIFT;
  assign ys = {{COORD_W{y_i[COORD_W-1]}}, y_i} << SHIFT;

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      x0_q <= xs[FW+31:FW];
      y0_q <= ys[FW+31:FW];
      fx_q <= xs[FW-1:0];
      fy_q <= ys[FW-1:0];
    end
  end

  // stage 2: lattice products, fraction squares
  logic [31:0] mx0_q, my0_q;
  logic [2*FW-1:0] sqx, sqy;
  logic [FW-1:0] t2x_q, t2y_q;
  logic [FW+1:0] kx_q, ky_q;

  assign sqx = (2*FW)'(fx_q) * (2*FW)'(fx_q);
  assign sqy = (2*FW)'(fy_q) * (2*FW)'(fy_q);

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      mx0_q <= mul32(x0_q, HASH_K1);
      my0_q <= mul32(y0_q, HASH_K2);
      t2x_q <= sqx[2*FW-1:FW];
      t2y_q <= sqy[2*FW-1:FW];
      kx_q  <= THREE_ONE - {1'b0, fx_q, 1'b0};
      ky_q  <= THREE_ONE - {1'b0, fy_q, 1'b0};
    end
  end

  // stage 3: seed mix and rotates per corner, smoothstep weights
  logic [31:0] mxs [2];
  logic [31:0] mys [2];
  logic [31:0] h3_d [4];
  logic [31:0] h3_q [4];
  logic [2*FW+1:0] ssx, ssy;
  logic [FW:0] sx_q [4];
  logic [FW:0] sy_q [5];

  assign mxs[0] = mx0_q;
  assign mxs[1] = mx0_q + HASH_K1;
  assign mys[0] = my0_q;
  assign mys[1] = my0_q + HASH_K2;
  assign ssx = (2*FW+2)'(t2x_q) * (2*FW+2)'(kx_q);
  assign ssy = (2*FW+2)'(t2y_q) * (2*FW+2)'(ky_q);

  always_comb begin
    logic [31:0] h;
    for (int c = 0; c < 4; c++) begin
      h = seed_i ^ mxs[c % 2];
      h = {h[18:0], h[31:19]};
      h = h ^ mys[c / 2];
      h3_d[c] = {h[14:0], h[31:15]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      h3_q     <= h3_d;
      sx_q[0]  <= ssx[2*FW:FW];
      sy_q[0]  <= ssy[2*FW:FW];
    end
  end

  // stages 4 to 6: finalizer multiplies
  logic [31:0] h4_q [4];
  logic [31:0] h5_q [4];
  logic [31:0] h6_q [4];

  always_ff @(posedge clk_i) begin
    if (adv_i[3]) begin
      for (int c = 0; c < 4; c++) h4_q[c] <= mul32(h3_q[c], HASH_K3);
      sx_q[1] <= sx_q[0];
      sy_q[1] <= sy_q[0];
    end
    if (adv_i[4]) begin
      for (int c = 0; c < 4; c++) h5_q[c] <= mul32(h4_q[c] ^ (h4_q[c] >> 15), HASH_K1);
      sx_q[2] <= sx_q[1];
      sy_q[2] <= sy_q[1];
    end
    if (adv_i[5]) begin
      for (int c = 0; c < 4; c++) h6_q[c] <= mul32(h5_q[c] ^ (h5_q[c] >> 13), HASH_K2);
      sx_q[3] <= sx_q[2];
      sy_q[3] <= sy_q[2];
    end
  end

  // stage 7: corner values and blend along x
  logic [31:0] hf [4];
  logic [OUT_W-1:0] top_q, bot_q;

  always_comb begin
    for (int c = 0; c < 4; c++) hf[c] = h6_q[c] ^ (h6_q[c] >> 16);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[6]) begin
      top_q   <= blend(hf[0][31:16], hf[1][31:16], sx_q[3]);
      bot_q   <= blend(hf[2][31:16], hf[3][31:16], sx_q[3]);
      sy_q[4] <= sy_q[3];
    end
  end

  // stage 8: blend along y
  logic [OUT_W-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[7]) begin
      val_q <= blend(top_q, bot_q, sy_q[4]);
    end
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

/* design/fractal_value_noise_core.sv */
// throughput: one coordinate pair per cycle while in_ready_o is high; a stalled
// output holds its stage and empty stages below it keep filling; the divider takes
// one quotient bit per stage
// reset clears all stage valid bits and loads seed 0, four octaves and 2d mode
// depends on fvn_pkg and fvn_octave
`default_nettype none

module fractal_value_noise_core import fvn_pkg::*; #(
  parameter int unsigned MAX_OCTAVES = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [31:0]          cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [COORD_W-1:0]   x_coord_i,
  input  wire logic [COORD_W-1:0]   y_coord_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [OUT_W-1:0]     noise_value_o
);

  localparam int unsigned NST      = PIPE_DEPTH;
  localparam int unsigned ST_SUMA  = 1 + LANE_STAGES;
  localparam int unsigned ST_SUMB  = ST_SUMA + 1;
  localparam int unsigned ST_PREP  = ST_SUMB + 1;
  localparam int unsigned ST_DIV0  = ST_PREP + 1;
  localparam int unsigned SUM_W    = OUT_W + MAX_OCTAVES;
  localparam int unsigned NGRP     = (MAX_OCTAVES + 3) / 4;

  // configuration
  logic [31:0] seed_q;
  logic [4:0]  oct_q;
  logic        twod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      oct_q  <= 5'd4;
      twod_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_SEED:    seed_q <= cfg_wdata_i;
        CFG_OCTAVES: oct_q  <= cfg_wdata_i[4:0];
        CFG_TWO_DIM: twod_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [4:0] n_sat;
  logic [MAX_OCTAVES:0] pw;
  logic [MAX_OCTAVES-1:0] dvs;

  assign n_sat = (oct_q > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : oct_q;
  assign pw    = (MAX_OCTAVES+1)'(1) << n_sat;
  assign dvs   = (n_sat == 5'd0) ? MAX_OCTAVES'(1)
                                 : pw[MAX_OCTAVES-1:0] - MAX_OCTAVES'(1);

  // stage valid bits and load chain
  logic [NST-1:0] v_q;
  logic [NST:0]   ld;

  assign ld[NST] = out_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_ld
    assign ld[k] = !v_q[k] || ld[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = ld[0];
  assign out_valid_o = v_q[NST-1];

  // stage 0: input register
  logic [COORD_W-1:0] x_q, y_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      x_q <= x_coord_i;
      y_q <= twod_q ? y_coord_i : '0;
    end
  end

  // stages 1 to 8: octave lanes
  logic [OUT_W-1:0] val [MAX_OCTAVES];

  for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
    localparam logic [31:0] LaneOfs = 32'(o) * SEED_STEP;
    fvn_octave #(
      .SHIFT     (o),
      .FRAC_BITS (FRAC_BITS)
    ) u_oct (
      .clk_i  (clk_i),
      .adv_i  (ld[LANE_STAGES:1]),
      .x_i    (x_q),
      .y_i    (y_q),
      .seed_i (seed_q + LaneOfs),
      .val_o  (val[o])
    );
  end

  // weighted sum over two adder stages
  logic [SUM_W-1:0] lw [NGRP*4];

  for (genvar l = 0; l < NGRP*4; l++) begin : g_lw
    if (l < MAX_OCTAVES) begin : g_act
      assign lw[l] = (5'(l) < n_sat) ? (SUM_W'(val[l]) << (MAX_OCTAVES - 1 - l)) : '0;
    end else begin : g_pad
      assign lw[l] = '0;
    end
  end

  logic [SUM_W-1:0] grp_q [NGRP];
  logic [SUM_W-1:0] sum_d, sum_q;

  always_ff @(posedge clk_i) begin
    if (ld[ST_SUMA]) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_q[g] <= lw[4*g] + lw[4*g+1] + lw[4*g+2] + lw[4*g+3];
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int g = 0; g < NGRP; g++) sum_d = sum_d + grp_q[g];
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_SUMB]) sum_q <= sum_d;
  end

  // divider setup: the weight total is 2^(max-n) * (2^n - 1)
  logic [SUM_W-1:0] qv;
  logic [MAX_OCTAVES-1:0] rem_q [OUT_W+1];
  logic [OUT_W-1:0]       quo_q [OUT_W+1];

  assign qv = (n_sat == 5'd0) ? '0 : (sum_q >> (5'(MAX_OCTAVES) - n_sat));

  always_ff @(posedge clk_i) begin
    if (ld[ST_PREP]) begin
      rem_q[0] <= qv[SUM_W-1:OUT_W];
      quo_q[0] <= qv[OUT_W-1:0];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < OUT_W; j++) begin : g_div
    logic [MAX_OCTAVES:0] r2, rs;
    logic ge;
    assign r2 = {rem_q[j], quo_q[j][OUT_W-1]};
    assign ge = (r2 >= {1'b0, dvs});
    assign rs = r2 - {1'b0, dvs};

    always_ff @(posedge clk_i) begin
      if (ld[ST_DIV0+j]) begin
        rem_q[j+1] <= ge ? rs[MAX_OCTAVES-1:0] : r2[MAX_OCTAVES-1:0];
        quo_q[j+1] <= {quo_q[j][OUT_W-2:0], ge};
      end
    end
  end

  assign noise_value_o = quo_q[OUT_W];

endmodule

`default_nettype wire

/* design/fvn_checker.sv */
// fractal value noise: port-level checker and its bind to the core
// depends on fvn_pkg and fractal_value_noise_core
`default_nettype none

module fvn_core_props import fvn_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [OUT_W-1:0] noise_value_o
);

  logic in_xfer, out_xfer;
  logic [5:0] cnt_d, cnt_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign cnt_d    = cnt_q + 6'(in_xfer) - 6'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(noise_value_o))
    else $error("output changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> cnt_q != 6'd0)
    else $error("output transfer with nothing in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 6'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && cnt_q == 6'(PIPE_DEPTH))
    else $error("input stalled while pipeline not full and blocked");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 6'd0 |-> in_ready_o && !out_valid_o)
    else $error("empty pipeline not ready or showing a result");

endmodule

bind fractal_value_noise_core fvn_core_props u_fvn_core_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .noise_value_o (noise_value_o)
);

`default_nettype wire

/* verif/fvn_checker.sv */
// fractal value noise checker: watches config writes and both transfer channels,
// predicts each noise sample and compares it with the core output
// depends on fvn_pkg
module fvn_checker import fvn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [COORD_W-1:0]   x_coord_i,
  input  logic [COORD_W-1:0]   y_coord_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [OUT_W-1:0]     noise_value_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXO = 16;
  localparam int FB   = 16;

  logic [31:0] seed_q;
  logic [4:0]  octaves_q;
  logic        two_dim_q;
  logic [OUT_W-1:0] noise_fifo[$];

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [63:0] corner(logic [31:0] lx, logic [31:0] ly, logic [31:0] sd);
    logic [31:0] h;
    h = sd;
    h ^= lx * HASH_K1;
    h = rotl(h, 13);
    h ^= ly * HASH_K2;
    h = rotl(h, 17);
    h *= HASH_K3;
    h ^= h >> 15;
    h *= HASH_K1;
    h ^= h >> 13;
    h *= HASH_K2;
    h ^= h >> 16;
    return 64'(h >> 16);
  endfunction

  function automatic logic [63:0] smooth(logic [63:0] t);
    logic [63:0] t2;
    t2 = (t * t) >> FB;
    return (t2 * ((64'd3 << FB) - 2 * t)) >> FB;
  endfunction

  function automatic logic [63:0] lerp(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * ((64'd1 << FB) - s) + b * s) >> FB;
  endfunction

  function automatic logic [OUT_W-1:0] predict_noise(logic [31:0] xc, logic [31:0] yc);
    logic [63:0] xs, ys, sx, sy, fx, fy, tx, ty, top, bot, sum, total, w;
    logic [31:0] x0, y0, sd;
    int n;
    xs = {{32{xc[31]}}, xc};
    ys = two_dim_q ? {{32{yc[31]}}, yc} : 64'd0;
    n = (octaves_q > MAXO) ? MAXO : octaves_q;
    sum = 0;
    total = 0;
    for (int i = 0; i < n; i++) begin
      sd = seed_q + 32'(i) * SEED_STEP;
      w = 64'd1 << (MAXO - 1 - i);
      sx = xs << i;
      sy = ys << i;
      x0 = sx[FB+31:FB];
      y0 = sy[FB+31:FB];
      fx = sx & ((64'd1 << FB) - 1);
      fy = sy & ((64'd1 << FB) - 1);
      tx = smooth(fx);
      ty = smooth(fy);
      top = lerp(corner(x0, y0, sd), corner(x0 + 1, y0, sd), tx);
      bot = lerp(corner(x0, y0 + 1, sd), corner(x0 + 1, y0 + 1, sd), tx);
      sum += lerp(top, bot, ty) * w;
      total += w;
    end
    return (total != 0) ? OUT_W'(sum / total) : '0;
  endfunction

  assign pending_o = noise_fifo.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OUT_W-1:0] exp_v;
    if (!rst_ni) begin
      seed_q <= '0;
      octaves_q <= 5'd4;
      two_dim_q <= 1'b1;
      fail_count_o <= 0;
      noise_fifo.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_SEED: begin
            seed_q <= cfg_wdata_i;
          end
          CFG_OCTAVES: begin
            octaves_q <= cfg_wdata_i[4:0];
          end
          CFG_TWO_DIM: begin
            two_dim_q <= cfg_wdata_i[0];
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        noise_fifo.push_back(predict_noise(x_coord_i, y_coord_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (noise_fifo.size() == 0) begin
          $display("%0t: unexpected noise_value %h", $time, noise_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_v = noise_fifo.pop_front();
          if (exp_v !== noise_value_i) begin
            $display("%0t: noise_value expected %h actual %h", $time, exp_v, noise_value_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

/* verif/testbench.sv */
// fractal value noise testbench top: clock, reset, config phases, coordinate stimulus
// with bursty sender and stalling receiver, verdict from the checker fail count
// depends on fvn_pkg, fvn_checker and fractal_value_noise_core
module testbench;
  import fvn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_addr_i;
  logic [31:0]          cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [COORD_W-1:0]   x_coord_i;
  logic [COORD_W-1:0]   y_coord_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b1;
  logic [OUT_W-1:0]     noise_value_o;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles = 0;
  int                   stall_mode;

  fractal_value_noise_core uut (.*);

  fvn_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .x_coord_i, .y_coord_i,
    .out_valid_i(out_valid_o), .out_ready_i, .noise_value_i(noise_value_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (pending == 0 && !in_valid_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 5000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall pattern, mode picked per phase
  always @(posedge clk_i) begin
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ($urandom_range(0, 15) > 7);
    endcase
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_coord(logic [31:0] xv, logic [31:0] yv, bit keep_going);
    in_valid_i <= 1'b1;
    x_coord_i <= xv;
    y_coord_i <= yv;
    do @(posedge clk_i); while (!in_ready_o);
    if (!keep_going) in_valid_i <= 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      default: return 32'($urandom_range(0, 16)) << 16 | 32'($urandom_range(0, 3)) << 14;
    endcase
  endfunction

  task automatic random_phase(int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      for (int k = 0; k < burst; k++) begin
        send_coord(rand_coord(), rand_coord(), k != burst - 1);
      end
      left -= burst;
      repeat ($urandom_range(0, 1) * $urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [31:0] edges[6];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = CFG_SEED;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    x_coord_i = '0;
    y_coord_i = '0;
    stall_mode = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config, extreme coordinates, lattice wrap
    edges = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000,
              32'hFFFF_0000};
    foreach (edges[a]) send_coord(edges[a], edges[5 - a], 1'b0);
    send_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_coord(32'h8000_0000, 32'h8000_0000, 1'b0);
    drain();
    // zero octaves
    write_reg(CFG_OCTAVES, 32'd0);
    send_coord(32'h0001_2345, 32'h0006_789A, 1'b0);
    send_coord(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    drain();
    // saturated octaves, 1d mode, extreme seed
    write_reg(CFG_OCTAVES, 32'd31);
    write_reg(CFG_TWO_DIM, 32'd0);
    write_reg(CFG_SEED, 32'hFFFF_FFFF);
    foreach (edges[a]) send_coord(edges[a], $urandom(), 1'b0);
    drain();
    write_reg(CFG_OCTAVES, 32'd16);
    write_reg(CFG_TWO_DIM, 32'd1);
    send_coord(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_coord(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    drain();

    // random phases over several settings
    for (int p = 0; p < 9; p++) begin
      write_reg(CFG_SEED, (p == 0) ? 32'h0 : $urandom());
      write_reg(CFG_OCTAVES, (p % 3 == 0) ? 32'd1 : 32'($urandom_range(0, 31)));
      write_reg(CFG_TWO_DIM, 32'(p % 4 != 1));
      stall_mode = p % 4;
      random_phase(50);
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
